// ----- rtl/arlm_pkg.sv -----
package arlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 17;
    localparam int SUM_W    = 43;
    localparam int COUNT_W  = 13;
    localparam int QUO_W    = 32;
    localparam int STEP_W   = 5;

    localparam logic [COUNT_W-1:0] MAX_FRAME     = 13'd4096;
    localparam logic [29:0]        FULL_SCALE_SQ = 30'd1073676289;
    localparam logic [LEVEL_W-1:0] UNITY         = 17'd65536;

    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd31;
    localparam logic [STEP_W-1:0] SQRT_LAST = 5'd15;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DEN,
        ST_CHECK,
        ST_DIV,
        ST_SQRT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic              acc_en;
        logic              den_load;
        logic              clamp_check;
        logic              div_step;
        logic              sqrt_step;
        logic              out_load;
        logic [STEP_W-2:0] step;
    } cmd_t;

    typedef struct packed {
        logic sum_ge_den;
    } sts_t;

endpackage

// ----- rtl/arlm_ctrl.sv -----
module arlm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                frame_end,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  arlm_pkg::sts_t      sts,
    output arlm_pkg::cmd_t      cmd
);

    arlm_pkg::state_t                state_reg;
    arlm_pkg::state_t                state_next;
    logic [arlm_pkg::STEP_W-1:0]     step_reg;
    logic [arlm_pkg::STEP_W-1:0]     step_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arlm_pkg::ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.step       = step_reg[arlm_pkg::STEP_W-2:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            arlm_pkg::ST_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc_en = 1'b1;
                    if (frame_end)
                    begin
                        state_next = arlm_pkg::ST_DEN;
                    end
                end
            end
            arlm_pkg::ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = arlm_pkg::ST_CHECK;
            end
            arlm_pkg::ST_CHECK:
            begin
                cmd.clamp_check = 1'b1;
                step_next       = '0;
                state_next      = sts.sum_ge_den ? arlm_pkg::ST_OUTPUT : arlm_pkg::ST_DIV;
            end
            arlm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == arlm_pkg::DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = arlm_pkg::ST_SQRT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            arlm_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == arlm_pkg::SQRT_LAST)
                begin
                    step_next  = '0;
                    state_next = arlm_pkg::ST_OUTPUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            arlm_pkg::ST_OUTPUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = arlm_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = arlm_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

// ----- rtl/arlm_dp.sv -----
module arlm_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [arlm_pkg::SAMPLE_W-1:0] sample,
    input  arlm_pkg::cmd_t                       cmd,
    output arlm_pkg::sts_t                       sts,
    output logic [arlm_pkg::LEVEL_W-1:0]         loudness,
    output logic                                 frame_too_long
);

    logic [arlm_pkg::SUM_W-1:0]   sum_reg;
    logic [arlm_pkg::SUM_W-1:0]   sum_next;
    logic [arlm_pkg::COUNT_W-1:0] count_reg;
    logic [arlm_pkg::COUNT_W-1:0] count_next;
    logic                         over_reg;
    logic                         over_next;
    logic [arlm_pkg::SUM_W-1:0]   den_reg;
    logic [arlm_pkg::SUM_W-1:0]   rem_reg;
    logic [arlm_pkg::SUM_W-1:0]   rem_next;
    logic [arlm_pkg::QUO_W-1:0]   quo_reg;
    logic [arlm_pkg::QUO_W-1:0]   quo_next;
    logic [arlm_pkg::QUO_W-1:0]   root_reg;
    logic [arlm_pkg::QUO_W-1:0]   root_next;
    logic                         clamp_reg;
    logic [arlm_pkg::LEVEL_W-1:0] level_reg;
    logic                         too_long_reg;

    logic signed [2*arlm_pkg::SAMPLE_W-1:0] square;
    logic [arlm_pkg::SUM_W:0]               shifted;
    logic [arlm_pkg::QUO_W-1:0]             sq_bit;
    logic [arlm_pkg::QUO_W-1:0]             sq_trial;

    assign square  = sample * sample;
    assign shifted = {rem_reg, 1'b0};
    assign sq_bit  = 32'h4000_0000 >> {cmd.step, 1'b0};
    assign sq_trial = root_reg + sq_bit;

    assign sts.sum_ge_den  = (sum_reg >= den_reg);
    assign loudness        = level_reg;
    assign frame_too_long  = too_long_reg;

    // accumulators
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        over_next  = over_reg;
        if (cmd.out_load)
        begin
            sum_next   = '0;
            count_next = '0;
            over_next  = 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (count_reg >= arlm_pkg::MAX_FRAME)
            begin
                over_next = 1'b1;
            end
            else
            begin
                sum_next   = sum_reg + arlm_pkg::SUM_W'(square[2*arlm_pkg::SAMPLE_W-2:0]);
                count_next = count_reg + 1'b1;
            end
        end
    end

    // restoring divide and bitwise square root
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        root_next = root_reg;
        if (cmd.den_load)
        begin
            rem_next  = sum_reg;
            quo_next  = '0;
            root_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = arlm_pkg::SUM_W'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[arlm_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[arlm_pkg::SUM_W-1:0];
                quo_next = {quo_reg[arlm_pkg::QUO_W-2:0], 1'b0};
            end
        end
        else if (cmd.sqrt_step)
        begin
            if (quo_reg >= sq_trial)
            begin
                quo_next  = quo_reg - sq_trial;
                root_next = (root_reg >> 1) + sq_bit;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            over_reg  <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            over_reg  <= over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        root_reg <= root_next;
        if (cmd.den_load)
        begin
            den_reg <= arlm_pkg::SUM_W'(count_reg) * arlm_pkg::SUM_W'(arlm_pkg::FULL_SCALE_SQ);
        end
        if (cmd.den_load)
        begin
            clamp_reg <= 1'b0;
        end
        else if (cmd.clamp_check)
        begin
            clamp_reg <= sts.sum_ge_den;
        end
        if (cmd.out_load)
        begin
            level_reg    <= clamp_reg ? arlm_pkg::UNITY : root_reg[arlm_pkg::LEVEL_W-1:0];
            too_long_reg <= over_reg;
        end
    end

endmodule

// ----- rtl/audio_rms_loudness_meter.sv -----
// rms loudness meter for signed 16-bit pcm frames
// input channel: sample and frame_end, taken when in_valid and in_ready are high
// output channel: loudness (unsigned q1.16, 65536 is full scale) and
//   frame_too_long, taken when out_valid and out_ready are high
// one result item per input item that has frame_end set, none otherwise
// within a frame the block takes one sample per cycle
// after the closing sample in_ready stays low while the level is worked out:
//   the full-scale product, the clamp compare, then, unless the level clamps,
//   the restoring divide and the square root, one bit a cycle, and the load of
//   the output register
// the result is registered in the output state, which follows the square root,
//   or the clamp compare when the level clamps to full scale, later if the output stalls
// the next frame's samples are taken while a result waits on the output;
//   a stalled output holds the block only when the next result is ready
// frames longer than 4096 samples keep the level of the first 4096 and flag it
// reset clears the sum, the count and the output valid; no clearing pass
module audio_rms_loudness_meter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [arlm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 frame_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [arlm_pkg::LEVEL_W-1:0]         loudness,
    output logic                                 frame_too_long
);

    arlm_pkg::cmd_t cmd;
    arlm_pkg::sts_t sts;

    arlm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    arlm_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .cmd            (cmd),
        .sts            (sts),
        .loudness       (loudness),
        .frame_too_long (frame_too_long)
    );

endmodule
